>>> src/fpba_pkg.sv
package fpba_pkg;

	localparam int IDX_W       = 4;
	localparam int SIZE_W      = 16;
	localparam int MODE_W      = 2;
	localparam int BCOUNT_W    = 5;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 5;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 40;

	localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_ALLOC = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'd1;

	localparam logic [BCOUNT_W-1:0] BLOCK_COUNT_RST = 5'd16;

	typedef struct packed {
		logic load;
		logic start;
		logic issue;
		logic finish;
	} fpba_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic inflight;
		logic out_free;
	} fpba_stat_t;

endpackage

>>> src/fpba_ram.sv
module fpba_ram import fpba_pkg::*; #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> src/fpba_ctrl.sv
module fpba_ctrl import fpba_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_op,
	output logic       s_tready,
	input  fpba_stat_t stat,
	output fpba_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		cmd        = '0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (s_op == OP_ALLOC) begin
						cmd.start = 1'b1;
						state_d   = ST_SCAN;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				cmd.issue = !stat.scan_done;
				if (stat.scan_done && !stat.inflight) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_start_scans: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> state_q == ST_SCAN)
		else $error("allocate did not enter scan");

endmodule

>>> src/fpba_dp.sv
module fpba_dp import fpba_pkg::*; #(
	parameter int NUM_BLOCKS = 16,
	parameter int SIZE_BITS  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [IDX_W-1:0]      in_index,
	input  logic [SIZE_W-1:0]     in_size,
	input  fpba_cmd_t             cmd,
	output fpba_stat_t            stat,
	input  logic                  m_tready,
	output logic                  m_tvalid,
	output logic                  out_granted,
	output logic [IDX_W-1:0]      out_index,
	output logic [SIZE_W-1:0]     out_before,
	output logic [SIZE_W-1:0]     out_after
);

	localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int CW = $clog2(NUM_BLOCKS + 1);

	logic [MODE_W-1:0]    fit_mode_q;
	logic [BCOUNT_W-1:0]  block_count_q;
	logic [SIZE_BITS-1:0] req_size_q;
	logic [CW-1:0]        cnt_q;
	logic [CW-1:0]        limit;
	logic                 rd_vld_s1;
	logic [AW-1:0]        rd_idx_s1;
	logic                 ent_vld_s1;
	logic [NUM_BLOCKS-1:0] valid_q;
	logic [SIZE_BITS-1:0] best_val_q;
	logic [AW-1:0]        best_idx_q;
	logic                 found_q;
	logic [SIZE_BITS-1:0] rd_data;
	logic [SIZE_BITS-1:0] ent_val;
	logic                 take;
	logic                 grant;
	logic [SIZE_BITS-1:0] after_val;
	logic                 load_ok;
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [SIZE_BITS-1:0] ram_wdata;
	logic                 m_valid_q;
	logic                 m_granted_q;
	logic [IDX_W-1:0]     m_idx_q;
	logic [SIZE_W-1:0]    m_before_q;
	logic [SIZE_W-1:0]    m_after_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q    <= MODE_FIRST;
			block_count_q <= BLOCK_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FIT_MODE:    fit_mode_q    <= cfg_data[MODE_W-1:0];
				CFG_BLOCK_COUNT: block_count_q <= cfg_data[BCOUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign limit = (32'(block_count_q) > NUM_BLOCKS) ? CW'(NUM_BLOCKS) : CW'(block_count_q);

	assign ent_val = ent_vld_s1 ? rd_data : '0;

	always_comb begin
		case (fit_mode_q)
			MODE_WORST: take = !found_q || (ent_val > best_val_q);
			MODE_BEST:  take = (ent_val >= req_size_q) && (!found_q || ent_val < best_val_q);
			default:    take = (ent_val >= req_size_q) && !found_q;
		endcase
	end

	assign grant     = found_q && (best_val_q >= req_size_q);
	assign after_val = best_val_q - req_size_q;
	assign load_ok   = 32'(in_index) < NUM_BLOCKS;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = AW'(in_index);
		ram_wdata = SIZE_BITS'(in_size);
		if (cmd.load && load_ok) begin
			ram_we = 1'b1;
		end else if (cmd.finish && grant) begin
			ram_we    = 1'b1;
			ram_waddr = best_idx_q;
			ram_wdata = after_val;
		end
	end

	fpba_ram #(
		.WIDTH (SIZE_BITS),
		.DEPTH (NUM_BLOCKS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (cnt_q[AW-1:0]),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rd_vld_s1 <= 1'b0;
			found_q   <= 1'b0;
			cnt_q     <= '0;
		end else begin
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			rd_vld_s1 <= cmd.issue;
			if (cmd.start) begin
				cnt_q   <= '0;
				found_q <= 1'b0;
			end else begin
				if (cmd.issue) begin
					cnt_q <= cnt_q + CW'(1);
				end
				if (rd_vld_s1 && take) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			req_size_q <= SIZE_BITS'(in_size);
		end
		rd_idx_s1  <= cnt_q[AW-1:0];
		ent_vld_s1 <= valid_q[cnt_q[AW-1:0]];
		if (rd_vld_s1 && take) begin
			best_val_q <= ent_val;
			best_idx_q <= rd_idx_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			m_granted_q <= grant;
			m_idx_q     <= grant ? IDX_W'(best_idx_q) : '0;
			m_before_q  <= grant ? SIZE_W'(best_val_q) : '0;
			m_after_q   <= grant ? SIZE_W'(after_val) : '0;
		end
	end

	assign stat.scan_done = (cnt_q == limit);
	assign stat.inflight  = rd_vld_s1;
	assign stat.out_free  = !m_valid_q || m_tready;

	assign m_tvalid    = m_valid_q;
	assign out_granted = m_granted_q;
	assign out_index   = m_idx_q;
	assign out_before  = m_before_q;
	assign out_after   = m_after_q;

	a_finish_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!m_valid_q || m_tready))
		else $error("result overwritten while stalled");

	a_issue_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> (cnt_q != limit))
		else $error("read issued beyond search limit");

	a_finish_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !rd_vld_s1)
		else $error("result taken with a read in flight");

	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && !m_granted_q) |-> (m_idx_q == '0 && m_before_q == '0 && m_after_q == '0))
		else $error("refused request carries nonzero fields");

endmodule

>>> src/fit_policy_block_allocator.sv
// Fit-policy block allocator.
// The input stream carries one request per beat: s_tuser is the operation (load or
// allocate), s_tdata holds the block index and the size. A load writes one entry of
// the free-size table; it produces no result. An allocate scans the first block_count
// entries (capped at NUM_BLOCKS), one table read per cycle from a memory with separate
// read and write ports, and picks a block by fit_mode (first, best or worst fit; the
// unused code acts as first fit). An allocate occupies the block while it is accepted,
// reads each entry, waits for the last read to return, closes the scan and writes back.
// The result is loaded into the output register together with the write-back and stays
// until taken. While a result waits, new loads and allocates are accepted; an allocate
// only stalls at write-back until the output register is free. Configuration writes
// through cfg_we, cfg_index and cfg_data take effect at once and must be made while
// idle. Reset marks every table entry invalid (each reads as zero until written), sets
// first fit and a block count of 16, and empties the output register.
module fit_policy_block_allocator import fpba_pkg::*; #(
	parameter int NUM_BLOCKS = 16,
	parameter int SIZE_BITS  = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // block_index[3:0], size_value[19:4], zeros
	input  logic                   s_tuser,   // operation
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // chosen_index[3:0], size_before[19:4],
	                                          // size_after[35:20], zeros
	output logic                   m_tuser    // granted
);

	fpba_cmd_t         cmd;
	fpba_stat_t        stat;
	logic [IDX_W-1:0]  out_index;
	logic [SIZE_W-1:0] out_before;
	logic [SIZE_W-1:0] out_after;

	fpba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_op     (s_tuser),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	fpba_dp #(
		.NUM_BLOCKS (NUM_BLOCKS),
		.SIZE_BITS  (SIZE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_index    (s_tdata[IDX_W-1:0]),
		.in_size     (s_tdata[IDX_W+SIZE_W-1:IDX_W]),
		.cmd         (cmd),
		.stat        (stat),
		.m_tready    (m_tready),
		.m_tvalid    (m_tvalid),
		.out_granted (m_tuser),
		.out_index   (out_index),
		.out_before  (out_before),
		.out_after   (out_after)
	);

	assign m_tdata = {4'b0, out_after, out_before, out_index};

endmodule

>>> sim/fit_policy_block_allocator_tb.sv
`timescale 1ns / 1ps

module fit_policy_block_allocator_tb;
	import fpba_pkg::*;

	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
	localparam int NUM_ENTRIES = 16;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_AT = 300;
	localparam int HOLD_CYCLES = 300;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_ITEMS = 140;

	typedef struct {
		logic              op;
		logic [IDX_W-1:0]  idx;
		logic [SIZE_W-1:0] size;
	} fpba_request_t;

	typedef struct {
		logic              granted;
		logic [IDX_W-1:0]  idx;
		logic [SIZE_W-1:0] prior_size;
		logic [SIZE_W-1:0] after;
	} fpba_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = CFG_FIT_MODE;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   s_tuser = OP_LOAD;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tuser;

	fit_policy_block_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	fpba_request_t pending_requests[$];
	fpba_result_t  expected_results[$];

	logic [SIZE_W-1:0] model_table[NUM_ENTRIES];
	logic [MODE_W-1:0] model_mode = MODE_FIRST;
	int unsigned       model_count = NUM_ENTRIES;

	logic quiet = 1'b0;
	int   fails = 0;
	int   requests_accepted = 0;
	int   loads_seen = 0;
	int   allocates_seen = 0;
	int   results_checked = 0;
	int   grants_seen = 0;
	int   settings_applied = 0;

	fpba_request_t cur_req;
	int            gap_left = 0;
	int            stall_left = 0;
	int            long_hold_left = 0;
	logic          long_hold_done = 1'b0;
	fpba_result_t  want;

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

	// Updates the table copy for one accepted request and, for an allocate, queues the result it causes.
	task automatic apply_request(input fpba_request_t r);
		int unsigned  limit;
		int unsigned  pick;
		logic         found;
		fpba_result_t res;
		pick = 0;
		found = 1'b0;
		if (r.op == OP_LOAD) begin
			loads_seen++;
			model_table[r.idx] = r.size;
			return;
		end
		allocates_seen++;
		limit = (model_count > NUM_ENTRIES) ? NUM_ENTRIES : model_count;
		for (int unsigned i = 0; i < limit; i++) begin
			if (model_mode == MODE_WORST) begin
				if (!found || model_table[i] > model_table[pick]) begin
					pick = i;
					found = 1'b1;
				end
			end else if (model_mode == MODE_BEST) begin
				if (model_table[i] >= r.size && (!found || model_table[i] < model_table[pick])) begin
					pick = i;
					found = 1'b1;
				end
			end else if (model_table[i] >= r.size && !found) begin
				pick = i;
				found = 1'b1;
			end
		end
		if (found && model_table[pick] < r.size)
			found = 1'b0;
		res.granted = found;
		res.idx = found ? pick[IDX_W-1:0] : '0;
		res.prior_size = found ? model_table[pick] : '0;
		res.after = found ? model_table[pick] - r.size : '0;
		if (found)
			model_table[pick] = res.after;
		expected_results.push_back(res);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= OP_LOAD;
			gap_left <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				apply_request(cur_req);
				requests_accepted <= requests_accepted + 1;
			end
			if (s_tvalid && !s_tready) begin
			end else if (gap_left != 0) begin
				s_tvalid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (!quiet && $urandom_range(0, 11) == 0) begin
				s_tvalid <= 1'b0;
				gap_left <= $urandom_range(0, 14);
			end else if (pending_requests.size() != 0) begin
				cur_req = pending_requests.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {{(IN_TDATA_W - SIZE_W - IDX_W){1'b0}}, cur_req.size, cur_req.idx};
				s_tuser <= cur_req.op;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left <= 0;
			long_hold_left <= 0;
			long_hold_done <= 1'b0;
		end else if (long_hold_left != 0) begin
			m_tready <= 1'b0;
			long_hold_left <= long_hold_left - 1;
		end else if (!long_hold_done && requests_accepted >= HOLD_AT) begin
			m_tready <= 1'b0;
			long_hold_left <= HOLD_CYCLES;
			long_hold_done <= 1'b1;
		end else if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!quiet && $urandom_range(0, 15) == 0) begin
			m_tready <= 1'b0;
			stall_left <= $urandom_range(0, 14);
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic check_field(input string name, input int unsigned exp_v,
			input int unsigned got_v);
		if (exp_v != got_v) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
			fails++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, actual granted %0b index %0d",
					$time, m_tuser, m_tdata[3:0]);
				fails++;
			end else begin
				want = expected_results.pop_front();
				results_checked++;
				if (want.granted)
					grants_seen++;
				check_field("granted", want.granted, m_tuser);
				check_field("chosen_index", want.idx, m_tdata[3:0]);
				check_field("size_before", want.prior_size, m_tdata[19:4]);
				check_field("size_after", want.after, m_tdata[35:20]);
			end
		end
	end

	task automatic wait_idle();
		@(negedge clk);
		while (pending_requests.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_fit_policy(input logic [MODE_W-1:0] mode, input int unsigned count);
		wait_idle();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_FIT_MODE;
		cfg_data <= CFG_DATA_W'(mode);
		@(posedge clk);
		cfg_index <= CFG_BLOCK_COUNT;
		cfg_data <= CFG_DATA_W'(count);
		@(posedge clk);
		cfg_we <= 1'b0;
		model_mode = mode;
		model_count = count;
		settings_applied++;
	endtask

	task automatic push_load(input int unsigned idx, input int unsigned size);
		fpba_request_t r;
		r.op = OP_LOAD;
		r.idx = IDX_W'(idx);
		r.size = SIZE_W'(size);
		pending_requests.push_back(r);
	endtask

	task automatic push_alloc(input int unsigned size);
		fpba_request_t r;
		r.op = OP_ALLOC;
		r.idx = IDX_W'($urandom_range(0, NUM_ENTRIES - 1));
		r.size = SIZE_W'(size);
		pending_requests.push_back(r);
	endtask

	function automatic int unsigned pick_load_size();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom_range(0, 1023);
			4:          return $urandom_range(0, 15);
			5, 6, 7:    return $urandom_range(0, 65535);
			8: begin
				case ($urandom_range(0, 3))
					0: return 0;
					1: return 1;
					2: return 16'hFFFE;
					default: return 16'hFFFF;
				endcase
			end
			default:    return $urandom_range(16'h8000, 16'hFFFF);
		endcase
	endfunction

	function automatic int unsigned pick_request_size();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return $urandom_range(0, 255);
			5:             return 0;
			6, 7:          return $urandom_range(0, 4095);
			8:             return $urandom_range(0, 65535);
			default:       return $urandom_range(1, 15);
		endcase
	endfunction

	initial begin
		logic [MODE_W-1:0] mode;
		int unsigned       count;
		for (int i = 0; i < NUM_ENTRIES; i++)
			model_table[i] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		set_fit_policy(MODE_FIRST, NUM_ENTRIES);
		push_alloc(0);
		push_alloc(1);
		push_load(15, 16'hFFFF);
		push_load(3, 16'h0010);
		push_load(9, 16'h0010);
		push_load(0, 16'h0004);
		push_alloc(16'h0010);
		push_alloc(16'hFFFF);
		push_alloc(0);

		set_fit_policy(MODE_BEST, NUM_ENTRIES);
		push_load(15, 16'h0020);
		push_alloc(16'h0008);
		push_alloc(16'h0008);
		push_alloc(16'h0021);

		set_fit_policy(MODE_WORST, NUM_ENTRIES);
		push_alloc(16'h0010);
		push_load(1, 16'h0010);
		push_alloc(16'h0001);
		push_alloc(16'h0100);

		set_fit_policy(MODE_SPARE, NUM_ENTRIES);
		push_alloc(16'h0004);

		set_fit_policy(MODE_FIRST, 0);
		push_alloc(0);

		set_fit_policy(MODE_WORST, 31);
		push_load(12, 16'h8000);
		push_alloc(16'h8000);

		set_fit_policy(MODE_BEST, 1);
		push_alloc(0);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case ($urandom_range(0, 9))
				0, 1, 2: mode = MODE_FIRST;
				3, 4, 5: mode = MODE_BEST;
				6, 7, 8: mode = MODE_WORST;
				default: mode = MODE_SPARE;
			endcase
			case ($urandom_range(0, 9))
				0:       count = ($urandom_range(0, 1) == 0) ? 0 : 31;
				1:       count = 1;
				2, 3, 4: count = NUM_ENTRIES;
				5:       count = $urandom_range(17, 31);
				default: count = $urandom_range(1, NUM_ENTRIES);
			endcase
			set_fit_policy(mode, count);
			if (p == RANDOM_PHASES - 1)
				quiet = 1'b1;
			// Each burst refills some blocks and then carves requests out of them.
			for (int n = 0; n < PHASE_ITEMS; ) begin
				for (int k = $urandom_range(1, 5); k > 0; k--, n++) begin
					if (count >= 1 && count < NUM_ENTRIES && $urandom_range(0, 9) < 7)
						push_load($urandom_range(0, count - 1), pick_load_size());
					else
						push_load($urandom_range(0, NUM_ENTRIES - 1), pick_load_size());
				end
				for (int k = $urandom_range(1, 12); k > 0; k--, n++)
					push_alloc(pick_request_size());
			end
		end

		wait_idle();
		$display("Covered %0d requests (%0d loads, %0d allocates) over %0d register settings.",
			requests_accepted, loads_seen, allocates_seen, settings_applied);
		$display("Checked %0d results, %0d granted and %0d refused.",
			results_checked, grants_seen, results_checked - grants_seen);
		if (fails == 0 && expected_results.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

>>> files.f
src/fpba_pkg.sv
src/fpba_ram.sv
src/fpba_ctrl.sv
src/fpba_dp.sv
src/fit_policy_block_allocator.sv
sim/fit_policy_block_allocator_tb.sv
